>>> rtl/core/lcdnx_pkg.sv
// lcdnx_pkg: shared types and constants for the nibble expander sequencer.
// No dependencies.

package lcdnx_pkg;

    localparam int WAIT_W = 16;
    localparam int OUT_WAIT_W = 17;
    localparam int PIN_W = 6;

    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_COMMAND = 2'd1;
    localparam logic [1:0] OP_CURSOR = 2'd2;
    localparam logic [1:0] OP_NIBBLE = 2'd3;

    localparam logic CFG_SHORT_WAIT = 1'b0;
    localparam logic CFG_COMMAND_WAIT = 1'b1;

    localparam logic [WAIT_W-1:0] SHORT_WAIT_RESET = 16'd300;
    localparam logic [WAIT_W-1:0] COMMAND_WAIT_RESET = 16'd3000;

    localparam logic [7:0] ROW1_OFFSET = 8'h40;
    localparam logic [7:0] ROW2_OFFSET = 8'h14;
    localparam logic [7:0] SET_DDRAM = 8'h80;

    localparam int PIN_E = 4;
    localparam int PIN_RS = 5;

    typedef enum logic [1:0] {
        EXTRA_NONE,
        EXTRA_SHORT,
        EXTRA_COMMAND
    } extra_t;

    typedef struct packed {
        logic       is_byte;
        logic       rs;
        logic [7:0] data;
        extra_t     extra;
    } cmd_t;

endpackage

>>> rtl/core/lcdnx_front.sv
// lcdnx_front: accepts input transactions and turns them into byte/nibble jobs.
// Depends on lcdnx_pkg.

module lcdnx_front
    import lcdnx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  value,
    input  logic [7:0]  column,
    input  logic [7:0]  row,
    output logic        push,
    input  logic        push_ready,
    output cmd_t        cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic [7:0] row_offset;

    assign in_ready = !valid_reg || push_ready;
    assign push = valid_reg;
    assign cmd = cmd_reg;

    always_comb
    begin
        if (row == 8'd1)
        begin
            row_offset = ROW1_OFFSET;
        end
        else if (row == 8'd2)
        begin
            row_offset = ROW2_OFFSET;
        end
        else
        begin
            row_offset = row;
        end
    end

    always_comb
    begin
        cmd_next = cmd_reg;
        unique case (operation)
            OP_DATA:
            begin
                cmd_next.is_byte = 1'b1;
                cmd_next.rs = 1'b1;
                cmd_next.data = value;
                cmd_next.extra = EXTRA_SHORT;
            end
            OP_COMMAND:
            begin
                cmd_next.is_byte = 1'b1;
                cmd_next.rs = 1'b0;
                cmd_next.data = value;
                cmd_next.extra = EXTRA_COMMAND;
            end
            OP_CURSOR:
            begin
                cmd_next.is_byte = 1'b1;
                cmd_next.rs = 1'b0;
                cmd_next.data = SET_DDRAM + row_offset + column;
                cmd_next.extra = EXTRA_COMMAND;
            end
            default:
            begin
                cmd_next.is_byte = 1'b0;
                cmd_next.rs = 1'b0;
                cmd_next.data = {4'd0, value[3:0]};
                cmd_next.extra = EXTRA_NONE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

>>> rtl/core/lcdnx_queue.sv
// lcdnx_queue: small job FIFO between front and back.
// Depends on lcdnx_pkg.

module lcdnx_queue
    import lcdnx_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic push_ready,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid = count_reg != '0;
    assign pop_cmd = mem_reg[rd_ptr_reg];
    assign do_push = push && push_ready;
    assign do_pop = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/lcdnx_back.sv
// lcdnx_back: pin sequencer; walks RS, nibble and enable steps per job.
// Keeps the pin shadow and the output register. Depends on lcdnx_pkg.

module lcdnx_back
    import lcdnx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_pop,
    input  cmd_t                  job,
    input  logic [WAIT_W-1:0]     short_wait,
    input  logic [WAIT_W-1:0]     command_wait,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIN_W-1:0]      expander_byte,
    output logic [OUT_WAIT_W-1:0] wait_after,
    output logic                  last
);

    localparam logic [3:0] STEP_RS = 4'd0;
    localparam logic [3:0] STEP_HI_END = 4'd6;
    localparam logic [3:0] STEP_LO_FIRST = 4'd7;
    localparam logic [3:0] STEP_LAST = 4'd12;

    logic                  active_reg, active_next;
    logic [3:0]            step_reg, step_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [PIN_W-1:0]      shadow_reg, shadow_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_WAIT_W-1:0] wait_reg, wait_next;
    logic                  last_reg, last_next;

    logic                  advance;
    logic [2:0]            sub;
    logic [3:0]            nib;
    logic [WAIT_W-1:0]     extra_wait;
    logic [PIN_W-1:0]      pins;
    logic [OUT_WAIT_W-1:0] step_wait;

    assign advance = active_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign expander_byte = shadow_reg;
    assign wait_after = wait_reg;
    assign last = last_reg;

    always_comb
    begin
        case (cmd_reg.extra)
            EXTRA_SHORT:   extra_wait = short_wait;
            EXTRA_COMMAND: extra_wait = command_wait;
            default:       extra_wait = '0;
        endcase
    end

    always_comb
    begin
        if (step_reg <= STEP_HI_END)
        begin
            sub = 3'(step_reg - 4'd1);
            nib = cmd_reg.data[7:4];
        end
        else
        begin
            sub = 3'(step_reg - STEP_LO_FIRST);
            nib = cmd_reg.data[3:0];
        end
    end

    // D4..D7 sit on bits 3..0; E goes high then low at the end of a nibble.
    always_comb
    begin
        pins = shadow_reg;
        step_wait = '0;
        if (step_reg == STEP_RS)
        begin
            pins[PIN_RS] = cmd_reg.rs;
        end
        else
        begin
            unique case (sub)
                3'd0: pins[3] = nib[0];
                3'd1: pins[2] = nib[1];
                3'd2: pins[1] = nib[2];
                3'd3: pins[0] = nib[3];
                3'd4:
                begin
                    pins[PIN_E] = 1'b1;
                    step_wait = {1'b0, short_wait};
                end
                default:
                begin
                    pins[PIN_E] = 1'b0;
                    step_wait = {1'b0, short_wait} + {1'b0, extra_wait};
                end
            endcase
        end
    end

    always_comb
    begin
        active_next = active_reg;
        step_next = step_reg;
        cmd_next = cmd_reg;
        shadow_next = shadow_reg;
        out_valid_next = out_valid_reg;
        wait_next = wait_reg;
        last_next = last_reg;
        job_pop = 1'b0;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            shadow_next = pins;
            wait_next = step_wait;
            last_next = step_reg == STEP_LAST;
            out_valid_next = 1'b1;
            step_next = step_reg + 4'd1;
            if (step_reg == STEP_LAST)
            begin
                active_next = 1'b0;
            end
        end

        if ((!active_reg || (advance && step_reg == STEP_LAST)) && job_valid)
        begin
            job_pop = 1'b1;
            active_next = 1'b1;
            cmd_next = job;
            step_next = job.is_byte ? STEP_RS : STEP_LO_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg <= STEP_RS;
            shadow_reg <= '0;
            out_valid_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg <= step_next;
            shadow_reg <= shadow_next;
            out_valid_reg <= out_valid_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        wait_reg <= wait_next;
    end

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> step_reg <= STEP_LAST)
        else $error("step counter out of range");

    a_last_e_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> !shadow_reg[PIN_E])
        else $error("final write leaves E high");

    a_e_high_wait: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_reg != STEP_RS && sub == 3'd4 |=>
            shadow_reg[PIN_E] && wait_reg == {1'b0, short_wait})
        else $error("E high write has wrong wait");

    a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> active_reg && (step_reg == STEP_RS || step_reg == STEP_LO_FIRST))
        else $error("job load did not start sequence");
`endif

endmodule

>>> rtl/core/lcd_nibble_expander_sequencer.sv
// lcd_nibble_expander_sequencer: top level of the 4-bit LCD port expander driver.
// Holds the wait registers; instantiates lcdnx_front, lcdnx_queue, lcdnx_back.
//
// Usage:
//   s_* carries one operation per transaction (data, command, cursor, raw nibble).
//   m_* carries one expander pin write per transaction with its wait count;
//   m_tlast marks the final write of an operation.
//   Byte operations produce 13 writes (RS, then two nibbles of D4..D7, E high,
//   E low); a raw nibble produces 6.
//   Throughput is set by the back-end sequencer, which emits one write per
//   cycle while m_tready is held.
//   From s_* acceptance a job passes the front register, the queue, the job
//   register and the output register. The front keeps accepting while the
//   queue has room, so a stalled m_* side fills the queue and then drops
//   s_tready; no write is lost. Reset clears the pin shadow to zero, empties
//   the queue and loads the wait registers with 300 and 3000. Registers are
//   written through cfg_* by the user only when idle; the block does not check.

module lcd_nibble_expander_sequencer
    import lcdnx_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // operation, value, column, row
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // expander_byte, wait_after
    output logic                m_tlast,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [WAIT_W-1:0]   cfg_data
);

    logic [WAIT_W-1:0]     short_wait_reg;
    logic [WAIT_W-1:0]     command_wait_reg;
    logic                  push;
    logic                  push_ready;
    cmd_t                  push_cmd;
    logic                  pop;
    logic                  pop_valid;
    cmd_t                  pop_cmd;
    logic [PIN_W-1:0]      expander_byte;
    logic [OUT_WAIT_W-1:0] wait_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_wait_reg <= SHORT_WAIT_RESET;
            command_wait_reg <= COMMAND_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SHORT_WAIT)
            begin
                short_wait_reg <= cfg_data;
            end
            else
            begin
                command_wait_reg <= cfg_data;
            end
        end
    end

    lcdnx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .operation  (s_tdata[1:0]),
        .value      (s_tdata[9:2]),
        .column     (s_tdata[17:10]),
        .row        (s_tdata[25:18]),
        .push       (push),
        .push_ready (push_ready),
        .cmd        (push_cmd)
    );

    lcdnx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    lcdnx_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (pop_valid),
        .job_pop       (pop),
        .job           (pop_cmd),
        .short_wait    (short_wait_reg),
        .command_wait  (command_wait_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .expander_byte (expander_byte),
        .wait_after    (wait_after),
        .last          (m_tlast)
    );

    assign m_tdata = {1'b0, wait_after, expander_byte};

endmodule
